/* rtl/gfp_pkg.sv */
package gfp_pkg;

  // Field widths of the result
  localparam int CHAR_W    = 8;
  localparam int DEG_W     = 10;
  localparam int FRAC_W    = 21;
  localparam int ALT_W     = 18;
  localparam int ALT_ACC_W = 17;

  // Altitude saturates at this magnitude
  localparam logic [ALT_ACC_W-1:0] ALT_LIMIT = 17'd99999;

  // Minute scaling: frac = minutes * 16667 / 1000
  // The divide is done as (p >> 3) / 125 with an exact reciprocal multiply.
  localparam int          PROD_W      = 31;
  localparam logic [15:0] MIN_SCALE   = 16'd16667;
  localparam int          RECIP_W     = 29;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;

  localparam logic [CHAR_W-1:0] MIN_LEN_RESET = 8'd29;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

  // Parser position within the reply
  typedef enum logic [3:0] {
    FLD_PROLOG,
    FLD_TIME,
    FLD_MSEC,
    FLD_LAT,
    FLD_LON,
    FLD_HDOP,
    FLD_ALT,
    FLD_FIX,
    FLD_TAIL
  } field_t;

  // Classified character handed from front to back
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              eom;
    logic              live;
    logic              digit;
    logic [3:0]        digit_val;
    logic              point;
    logic              comma;
    logic              colon;
    logic              space;
    logic              blank;
    logic              minus;
    logic              plus;
  } tok_t;

  // Scaled minute fraction coming out of the scaling pipeline
  typedef struct packed {
    logic              valid;
    logic              lon;
    logic [FRAC_W-1:0] frac;
  } frac_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

/* rtl/gfp_if.sv */
interface gfp_in_if
  import gfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_message;

  modport source (output valid, char_code, end_of_message, input ready);
  modport sink (input valid, char_code, end_of_message, output ready);
endinterface

interface gfp_out_if
  import gfp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CHAR_W-1:0]        fix_char;
  logic                     fix_present;
  logic [DEG_W-1:0]         lat_degrees;
  logic [FRAC_W-1:0]        lat_fraction;
  logic [DEG_W-1:0]         lon_degrees;
  logic [FRAC_W-1:0]        lon_fraction;
  logic signed [ALT_W-1:0]  altitude;

  modport source (output valid, fix_char, fix_present, lat_degrees, lat_fraction,
                  lon_degrees, lon_fraction, altitude, input ready);
  modport sink (input valid, fix_char, fix_present, lat_degrees, lat_fraction,
                lon_degrees, lon_fraction, altitude, output ready);
endinterface

/* rtl/gfp_front.sv */
module gfp_front
  import gfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  gfp_in_if.sink chars,
  output logic   tok_valid,
  input  logic   tok_ready,
  output tok_t   tok
);

  logic terminated;
  logic take;
  logic [CHAR_W-1:0] c;

  assign c           = chars.char_code;
  assign take        = chars.valid && chars.ready;
  assign chars.ready = tok_ready;
  assign tok_valid   = chars.valid;

  // Classify the character
  always_comb begin
    tok.char_code = c;
    tok.eom       = chars.end_of_message;
    tok.live      = !terminated && (c != CH_NUL);
    tok.digit     = is_digit(c);
    tok.digit_val = c[3:0];
    tok.point     = (c == CH_POINT);
    tok.comma     = (c == CH_COMMA);
    tok.colon     = (c == CH_COLON);
    tok.space     = (c == CH_SPACE);
    tok.blank     = (c >= CH_TAB) && (c <= CH_CR);
    tok.minus     = (c == CH_MINUS);
    tok.plus      = (c == CH_PLUS);
  end

  // Drop everything after a zero character until the end of the reply
  always_ff @(posedge clk) begin
    if (rst) begin
      terminated <= 1'b0;
    end else if (take) begin
      if (chars.end_of_message) begin
        terminated <= 1'b0;
      end else if (c == CH_NUL) begin
        terminated <= 1'b1;
      end
    end
  end

endmodule

/* rtl/gfp_queue.sv */
module gfp_queue
  import gfp_pkg::*;
#(
  parameter int DEPTH = 4
)
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  tok_t push_tok,
  output logic pop_valid,
  input  logic pop_ready,
  output tok_t pop_tok
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_tok    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

endmodule

/* rtl/gfp_scale.sv */
module gfp_scale
  import gfp_pkg::*;
#(
  parameter int MIN_W = 17
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             lon,
  input  logic [MIN_W-1:0] minutes,
  output frac_t            result
);

  logic [PROD_W-1:0]         prod;
  logic                      prod_valid;
  logic                      prod_lon;
  logic [PROD_W+RECIP_W-4:0] quot_wide;
  logic                      res_valid;
  logic                      res_lon;
  logic [FRAC_W-1:0]         res_frac;

  // Divide by 1000: drop three bits, then multiply by the reciprocal of 125
  assign quot_wide = {{RECIP_W{1'b0}}, prod[PROD_W-1:3]} *
                     {{(PROD_W-3){1'b0}}, RECIP_125};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      prod_valid <= start;
      res_valid  <= prod_valid;
    end
  end

  // Stage one multiplies by 16667, stage two divides
  always_ff @(posedge clk) begin
    prod     <= {{(PROD_W-MIN_W){1'b0}}, minutes} * {{(PROD_W-16){1'b0}}, MIN_SCALE};
    prod_lon <= lon;
    res_frac <= quot_wide[RECIP_SHIFT +: FRAC_W];
    res_lon  <= prod_lon;
  end

  assign result.valid = res_valid;
  assign result.lon   = res_lon;
  assign result.frac  = res_frac;

endmodule

/* rtl/gfp_back.sv */
module gfp_back
  import gfp_pkg::*;
#(
  parameter int MAX_DEGREE_DIGITS = 3,
  parameter int MINUTE_DIGITS     = 5
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CHAR_W-1:0] min_len,
  input  logic              tok_valid,
  output logic              tok_ready,
  input  tok_t              tok,
  gfp_out_if.source         fixes
);

  localparam int DEG_LIMIT = (MAX_DEGREE_DIGITS >= 3) ? 999 : 99;
  localparam int DEG_ACC_W = $clog2(DEG_LIMIT + 1);
  localparam int MIN_W     = $clog2(10 ** MINUTE_DIGITS);
  localparam int MCNT_W    = $clog2(MINUTE_DIGITS + 1);

  typedef struct packed {
    logic [MIN_W-1:0]  acc;
    logic [MCNT_W-1:0] cnt;
    logic              stop;
  } minute_st_t;

  typedef struct packed {
    logic [DEG_ACC_W-1:0] acc;
    logic                 stop;
  } deg_st_t;

  function automatic minute_st_t minute_take(input minute_st_t s,
                                             input logic [CHAR_W-1:0] c);
    minute_st_t       r;
    logic [MIN_W+3:0] wide;
    r    = s;
    wide = {4'd0, s.acc};
    if (s.cnt < MCNT_W'(MINUTE_DIGITS)) begin
      r.cnt = s.cnt + 1'b1;
      if (!s.stop) begin
        if (!is_digit(c)) begin
          r.stop = 1'b1;
        end else begin
          wide  = (wide << 3) + (wide << 1) + (MIN_W+4)'(c[3:0]);
          r.acc = wide[MIN_W-1:0];
        end
      end
    end
    return r;
  endfunction

  function automatic deg_st_t deg_take(input deg_st_t s, input logic [CHAR_W-1:0] c);
    deg_st_t              r;
    logic [DEG_ACC_W+3:0] wide;
    r    = s;
    wide = {4'd0, s.acc};
    if (!s.stop) begin
      if (!is_digit(c)) begin
        r.stop = 1'b1;
      end else begin
        wide = (wide << 3) + (wide << 1) + (DEG_ACC_W+4)'(c[3:0]);
        if (wide > (DEG_ACC_W+4)'(DEG_LIMIT)) begin
          r.acc = DEG_ACC_W'(DEG_LIMIT);
        end else begin
          r.acc = wide[DEG_ACC_W-1:0];
        end
      end
    end
    return r;
  endfunction

  // Parse state
  field_t               field, field_next;
  logic [CHAR_W-1:0]    char_count, char_count_next;
  deg_st_t              deg, deg_next;
  logic [CHAR_W-1:0]    pend0, pend0_next;
  logic [CHAR_W-1:0]    pend1, pend1_next;
  logic [1:0]           pend_n, pend_n_next;
  logic                 after_point, after_point_next;
  minute_st_t           mst, mst_next;
  logic [ALT_ACC_W-1:0] alt_acc, alt_acc_next;
  logic                 alt_neg, alt_neg_next;
  logic                 alt_started, alt_started_next;
  logic                 alt_done, alt_done_next;
  logic [CHAR_W-1:0]    parsed_fix, parsed_fix_next;

  // Stored position and result register
  logic [DEG_W-1:0]        st_lat_deg, st_lat_deg_next;
  logic [FRAC_W-1:0]       st_lat_frac, st_lat_frac_next;
  logic [DEG_W-1:0]        st_lon_deg, st_lon_deg_next;
  logic [FRAC_W-1:0]       st_lon_frac, st_lon_frac_next;
  logic signed [ALT_W-1:0] st_alt, st_alt_next;
  logic                    out_valid, out_valid_next;
  logic [CHAR_W-1:0]       out_fix_char, out_fix_char_next;
  logic                    out_fix_present, out_fix_present_next;

  // Finished coordinates of the reply in progress
  logic [DEG_W-1:0]  tmp_lat_deg;
  logic [DEG_W-1:0]  tmp_lon_deg;
  logic [FRAC_W-1:0] tmp_lat_frac;
  logic [FRAC_W-1:0] tmp_lon_frac;

  logic                 take;
  logic                 update;
  logic                 fin;
  logic                 fin_lon;
  minute_st_t           m_step;
  logic [ALT_ACC_W+3:0] alt_wide;
  frac_t                scale_res;

  // Hold an end-of-reply transaction while the result register is occupied and not being taken
  assign tok_ready = !tok.eom || !out_valid || fixes.ready;
  assign take      = tok_valid && tok_ready;

  gfp_scale #(
    .MIN_W (MIN_W)
  ) u_scale (
    .clk     (clk),
    .rst     (rst),
    .start   (fin),
    .lon     (fin_lon),
    .minutes (mst.acc),
    .result  (scale_res)
  );

  // Next-state logic of the parser
  always_comb begin
    field_next           = field;
    char_count_next      = char_count;
    deg_next             = deg;
    pend0_next           = pend0;
    pend1_next           = pend1;
    pend_n_next          = pend_n;
    after_point_next     = after_point;
    mst_next             = mst;
    alt_acc_next         = alt_acc;
    alt_neg_next         = alt_neg;
    alt_started_next     = alt_started;
    alt_done_next        = alt_done;
    parsed_fix_next      = parsed_fix;
    st_lat_deg_next      = st_lat_deg;
    st_lat_frac_next     = st_lat_frac;
    st_lon_deg_next      = st_lon_deg;
    st_lon_frac_next     = st_lon_frac;
    st_alt_next          = st_alt;
    out_valid_next       = out_valid;
    out_fix_char_next    = out_fix_char;
    out_fix_present_next = out_fix_present;
    update               = 1'b0;
    fin                  = 1'b0;
    fin_lon              = 1'b0;
    m_step               = mst;
    alt_wide             = {4'd0, alt_acc};

    if (take && tok.live) begin
      if (char_count != {CHAR_W{1'b1}}) begin
        char_count_next = char_count + 1'b1;
      end
      case (field)
        FLD_PROLOG: begin
          if (tok.colon) field_next = FLD_TIME;
        end
        FLD_TIME: begin
          if (tok.point) field_next = FLD_MSEC;
        end
        FLD_MSEC: begin
          if (tok.comma) field_next = FLD_LAT;
        end
        FLD_LAT, FLD_LON: begin
          if (tok.comma) begin
            // Finish the coordinate and start the fraction scaling
            fin              = 1'b1;
            fin_lon          = (field == FLD_LON);
            field_next       = (field == FLD_LAT) ? FLD_LON : FLD_HDOP;
            deg_next         = '0;
            pend0_next       = '0;
            pend1_next       = '0;
            pend_n_next      = '0;
            after_point_next = 1'b0;
            mst_next         = '0;
          end else if (!tok.space) begin
            if (tok.point) begin
              // Flush the held integer characters, up to two, into the minutes
              if (!after_point) begin
                after_point_next = 1'b1;
                if (pend_n != 2'd0) m_step = minute_take(m_step, pend0);
                if (pend_n == 2'd2) m_step = minute_take(m_step, pend1);
                mst_next = m_step;
              end
            end else if (after_point) begin
              mst_next = minute_take(mst, tok.char_code);
            end else if (pend_n == 2'd2) begin
              deg_next   = deg_take(deg, pend0);
              pend0_next = pend1;
              pend1_next = tok.char_code;
            end else if (pend_n == 2'd1) begin
              pend1_next  = tok.char_code;
              pend_n_next = 2'd2;
            end else begin
              pend0_next  = tok.char_code;
              pend_n_next = 2'd1;
            end
          end
        end
        FLD_HDOP: begin
          if (tok.comma) field_next = FLD_ALT;
        end
        FLD_ALT: begin
          if (tok.comma) begin
            field_next = FLD_FIX;
          end else if (!tok.space && !alt_done) begin
            if (!alt_started && tok.blank) begin
              alt_started_next = 1'b0;
            end else if (!alt_started && tok.minus) begin
              alt_neg_next     = 1'b1;
              alt_started_next = 1'b1;
            end else if (!alt_started && tok.plus) begin
              alt_started_next = 1'b1;
            end else if (tok.digit) begin
              alt_started_next = 1'b1;
              alt_wide = (alt_wide << 3) + (alt_wide << 1) +
                         (ALT_ACC_W+4)'(tok.digit_val);
              if (alt_wide > {4'd0, ALT_LIMIT}) begin
                alt_acc_next = ALT_LIMIT;
              end else begin
                alt_acc_next = alt_wide[ALT_ACC_W-1:0];
              end
            end else begin
              alt_done_next = 1'b1;
            end
          end
        end
        FLD_FIX: begin
          parsed_fix_next = tok.char_code;
          field_next      = FLD_TAIL;
        end
        default: begin
          field_next = field;
        end
      endcase
    end

    if (take && tok.eom) begin
      // Commit the parsed position on a valid fix and load the result register
      update = (char_count_next > min_len) && (parsed_fix_next != CH_NUL) &&
               (parsed_fix_next != CH_ZERO);
      out_valid_next       = 1'b1;
      out_fix_char_next    = update ? parsed_fix_next : CH_NUL;
      out_fix_present_next = update;
      if (update) begin
        st_lat_deg_next  = tmp_lat_deg;
        st_lat_frac_next = tmp_lat_frac;
        st_lon_deg_next  = tmp_lon_deg;
        st_lon_frac_next = tmp_lon_frac;
        st_alt_next      = alt_neg ? -$signed({1'b0, alt_acc_next})
                                   : $signed({1'b0, alt_acc_next});
      end
      field_next       = FLD_PROLOG;
      char_count_next  = '0;
      deg_next         = '0;
      pend0_next       = '0;
      pend1_next       = '0;
      pend_n_next      = '0;
      after_point_next = 1'b0;
      mst_next         = '0;
      alt_acc_next     = '0;
      alt_neg_next     = 1'b0;
      alt_started_next = 1'b0;
      alt_done_next    = 1'b0;
      parsed_fix_next  = '0;
    end else if (out_valid && fixes.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field       <= FLD_PROLOG;
      char_count  <= '0;
      deg         <= '0;
      pend0       <= '0;
      pend1       <= '0;
      pend_n      <= '0;
      after_point <= 1'b0;
      mst         <= '0;
      alt_acc     <= '0;
      alt_neg     <= 1'b0;
      alt_started <= 1'b0;
      alt_done    <= 1'b0;
      parsed_fix  <= '0;
      st_lat_deg  <= '0;
      st_lat_frac <= '0;
      st_lon_deg  <= '0;
      st_lon_frac <= '0;
      st_alt      <= '0;
      out_valid   <= 1'b0;
    end else begin
      field       <= field_next;
      char_count  <= char_count_next;
      deg         <= deg_next;
      pend0       <= pend0_next;
      pend1       <= pend1_next;
      pend_n      <= pend_n_next;
      after_point <= after_point_next;
      mst         <= mst_next;
      alt_acc     <= alt_acc_next;
      alt_neg     <= alt_neg_next;
      alt_started <= alt_started_next;
      alt_done    <= alt_done_next;
      parsed_fix  <= parsed_fix_next;
      st_lat_deg  <= st_lat_deg_next;
      st_lat_frac <= st_lat_frac_next;
      st_lon_deg  <= st_lon_deg_next;
      st_lon_frac <= st_lon_frac_next;
      st_alt      <= st_alt_next;
      out_valid   <= out_valid_next;
    end
  end

  // Capture finished degrees and scaled fractions; load result payload
  always_ff @(posedge clk) begin
    if (fin && !fin_lon) tmp_lat_deg <= DEG_W'(deg.acc);
    if (fin && fin_lon) tmp_lon_deg <= DEG_W'(deg.acc);
    if (scale_res.valid && !scale_res.lon) tmp_lat_frac <= scale_res.frac;
    if (scale_res.valid && scale_res.lon) tmp_lon_frac <= scale_res.frac;
    out_fix_char    <= out_fix_char_next;
    out_fix_present <= out_fix_present_next;
  end

  assign fixes.valid        = out_valid;
  assign fixes.fix_char     = out_fix_char;
  assign fixes.fix_present  = out_fix_present;
  assign fixes.lat_degrees  = st_lat_deg;
  assign fixes.lat_fraction = st_lat_frac;
  assign fixes.lon_degrees  = st_lon_deg;
  assign fixes.lon_fraction = st_lon_frac;
  assign fixes.altitude     = st_alt;

endmodule

/* rtl/gps_fix_response_parser.sv */
// GPS position reply parser.
// Channels: "chars" takes one reply character per transaction, with
// end_of_message set on the last one. "fixes" gives one transaction per
// reply: the fix character and flag, and the stored latitude, longitude and
// altitude. cfg_wr_en/cfg_wr_data write the minimum reply length; write it
// only while no reply is in flight.
// Throughput: one character per cycle unless a held result stalls the parser.
// A front stage classifies each character into a four-entry queue; the parser
// behind it takes one entry per cycle when not stalled. The result register
// loads when the parser takes the last character of a reply from the queue.
// Minute fractions run through a two-stage multiply pipeline that finishes
// before any reply can end with a fix.
// Reset: the stored position is zero, the minimum length is 29, the queue is
// empty and the parser waits for the prolog.
// Stall: a result waits in the output register until taken; the parser holds
// the next end-of-reply transaction behind it, the queue fills and then
// chars.ready drops.
module gps_fix_response_parser
  import gfp_pkg::*;
#(
  parameter int MAX_DEGREE_DIGITS = 3,
  parameter int MINUTE_DIGITS     = 5,
  parameter int QUEUE_DEPTH       = 4
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CHAR_W-1:0] cfg_wr_data,
  gfp_in_if.sink            chars,
  gfp_out_if.source         fixes
);

  localparam int DEG_LIMIT = (MAX_DEGREE_DIGITS >= 3) ? 999 : 99;

  logic [CHAR_W-1:0] min_len;
  logic              f_valid;
  logic              f_ready;
  tok_t              f_tok;
  logic              b_valid;
  logic              b_ready;
  tok_t              b_tok;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      min_len <= cfg_wr_data;
    end
  end

  gfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  gfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_tok    (b_tok)
  );

  gfp_back #(
    .MAX_DEGREE_DIGITS (MAX_DEGREE_DIGITS),
    .MINUTE_DIGITS     (MINUTE_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .min_len   (min_len),
    .tok_valid (b_valid),
    .tok_ready (b_ready),
    .tok       (b_tok),
    .fixes     (fixes)
  );

  // A reported fix never carries a null or '0' fix character
  a_fix_char_valid: assert property (@(posedge clk) disable iff (rst)
    fixes.valid && fixes.fix_present |-> fixes.fix_char != CH_NUL &&
                                         fixes.fix_char != CH_ZERO)
    else $error("fix reported with invalid fix character");

  // Without a fix the fix character reads zero
  a_no_fix_zero: assert property (@(posedge clk) disable iff (rst)
    fixes.valid && !fixes.fix_present |-> fixes.fix_char == CH_NUL)
    else $error("fix character set without a fix");

  // Degrees stay within the saturation limit
  a_deg_limit: assert property (@(posedge clk) disable iff (rst)
    fixes.valid |-> fixes.lat_degrees <= DEG_W'(DEG_LIMIT) &&
                    fixes.lon_degrees <= DEG_W'(DEG_LIMIT))
    else $error("degrees above limit");

  // Stored altitude and latitude fraction only change when a fix is reported
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    fixes.valid && !fixes.fix_present && $past(fixes.valid) && !$past(rst) |->
      fixes.altitude == $past(fixes.altitude) &&
      fixes.lat_fraction == $past(fixes.lat_fraction))
    else $error("stored position changed without a fix");

endmodule
